[sv/assert_macros.svh]
// Assertion helpers for the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent check, disabled while reset is asserted.
`define CKALU_ASSERT(label, clk, rstn, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);

// Concurrent check that also holds across reset.
`define CKALU_ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

[sv/ckalu_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ckalu_pkg
// Shared types and constants of the checked 64-bit integer ALU.
// ----------------------------------------------------------------------------
package ckalu_pkg;

    localparam int DATA_W  = 64;
    localparam int SHAMT_W = 6;
    localparam int NUM_CELLS = DATA_W;

    localparam logic [DATA_W-1:0] MIN_INT = {1'b1, {(DATA_W-1){1'b0}}};
    localparam logic [DATA_W-1:0] MAX_INT = {1'b0, {(DATA_W-1){1'b1}}};

    typedef enum logic [2:0] {
        OP_ADD = 3'd0,
        OP_SUB = 3'd1,
        OP_MUL = 3'd2,
        OP_DIV = 3'd3,
        OP_MOD = 3'd4,
        OP_SHL = 3'd5,
        OP_SHR = 3'd6
    } op_t;

    typedef struct packed {
        logic [2:0]        op;
        logic              neg_a;
        logic              neg_b;
        logic              err;
        logic [DATA_W-1:0] res;
        logic [DATA_W:0]   hi;
        logic [DATA_W-1:0] lo;
        logic [DATA_W-1:0] m;
    } word_t;

endpackage

[sv/checked_int64_alu_unit.sv]
`timescale 1ns / 1ps
// Pipeline: 64 step cells plus output register between input accept and result valid.
// Throughput: one word per cycle; each cell holds one word and does one multiply or divide step.
// Backpressure reaches the input in the same cycle through the ready chain; empty cells still
// accept, so bubbles are squeezed out under backpressure.
// Reset: aresetn, synchronous, active low; clears all valid bits, payload is not reset.
// ----------------------------------------------------------------------------
// checked_int64_alu_unit
// Overflow-checked 64-bit integer ALU built as a chain of step cells.
// ----------------------------------------------------------------------------
module checked_int64_alu_unit
    import ckalu_pkg::*;
(
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     s_valid,
    output logic                     s_ready,
    input  logic [2:0]               s_req_type,
    input  logic signed [DATA_W-1:0] s_operand_a,
    input  logic signed [DATA_W-1:0] s_operand_b,
    output logic                     m_valid,
    input  logic                     m_ready,
    output logic signed [DATA_W-1:0] m_value,
    output logic                     m_range_error
);

    word_t chain_word  [NUM_CELLS+1];
    logic  chain_valid [NUM_CELLS+1];
    logic  chain_ready [NUM_CELLS+1];

    ckalu_front u_front (
        .req_type  (s_req_type),
        .operand_a (s_operand_a),
        .operand_b (s_operand_b),
        .word      (chain_word[0])
    );

    assign chain_valid[0] = s_valid;
    assign s_ready        = chain_ready[0];

    for (genvar i = 0; i < NUM_CELLS; i++) begin : g_cell
        ckalu_cell u_cell (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .in_valid  (chain_valid[i]),
            .in_ready  (chain_ready[i]),
            .in_word   (chain_word[i]),
            .out_valid (chain_valid[i+1]),
            .out_ready (chain_ready[i+1]),
            .out_word  (chain_word[i+1])
        );
    end

    ckalu_back u_back (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .in_valid      (chain_valid[NUM_CELLS]),
        .in_ready      (chain_ready[NUM_CELLS]),
        .in_word       (chain_word[NUM_CELLS]),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_value       (m_value),
        .m_range_error (m_range_error)
    );

endmodule

[sv/ckalu_front.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ckalu_front
// Decode: add, sub and shifts, error checks, operand magnitudes for the chain.
// ----------------------------------------------------------------------------
module ckalu_front
    import ckalu_pkg::*;
(
    input  logic [2:0]               req_type,
    input  logic signed [DATA_W-1:0] operand_a,
    input  logic signed [DATA_W-1:0] operand_b,
    output word_t                    word
);

    logic [DATA_W-1:0] a;
    logic [DATA_W-1:0] b;
    logic [DATA_W-1:0] sum;
    logic [DATA_W-1:0] diff;
    logic [DATA_W-1:0] mag_a;
    logic [DATA_W-1:0] mag_b;
    logic              na;
    logic              nb;
    logic              shamt_bad;

    assign a     = operand_a;
    assign b     = operand_b;
    assign na    = a[DATA_W-1];
    assign nb    = b[DATA_W-1];
    assign sum   = a + b;
    assign diff  = a - b;
    assign mag_a = na ? (~a + 1'b1) : a;
    assign mag_b = nb ? (~b + 1'b1) : b;
    assign shamt_bad = |b[DATA_W-1:SHAMT_W];

    always_comb begin
        word       = '0;
        word.op    = req_type;
        word.neg_a = na;
        word.neg_b = nb;
        word.lo    = mag_a;
        word.m     = mag_b;
        case (req_type)
            OP_ADD: begin
                word.res = sum;
                word.err = (na == nb) && (sum[DATA_W-1] != na);
            end
            OP_SUB: begin
                word.res = diff;
                word.err = (na != nb) && (diff[DATA_W-1] != na);
            end
            OP_MUL: begin
                word.lo = mag_b;
                word.m  = mag_a;
            end
            OP_DIV, OP_MOD: begin
                word.err = (b == '0) || ((a == MIN_INT) && (b == {DATA_W{1'b1}}));
            end
            OP_SHL: begin
                word.res = a << b[SHAMT_W-1:0];
                word.err = shamt_bad;
            end
            OP_SHR: begin
                word.res = DATA_W'($signed(a) >>> b[SHAMT_W-1:0]);
                word.err = shamt_bad;
            end
            default: begin
                word.err = 1'b1;
            end
        endcase
    end

endmodule

[sv/ckalu_cell.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ckalu_cell
// One step of shift-add multiply or restoring divide, with its own stage.
// ----------------------------------------------------------------------------
module ckalu_cell
    import ckalu_pkg::*;
(
    input  logic  aclk,
    input  logic  aresetn,
    input  logic  in_valid,
    output logic  in_ready,
    input  word_t in_word,
    output logic  out_valid,
    input  logic  out_ready,
    output word_t out_word
);

    logic              valid_reg;
    word_t             word_reg;
    word_t             word_next;
    logic [DATA_W:0]   add_sum;
    logic [DATA_W:0]   sh_hi;
    logic [DATA_W+1:0] sub_diff;

    assign add_sum  = in_word.lo[0] ? (in_word.hi + {1'b0, in_word.m}) : in_word.hi;
    assign sh_hi    = {in_word.hi[DATA_W-1:0], in_word.lo[DATA_W-1]};
    assign sub_diff = {1'b0, sh_hi} - {2'b00, in_word.m};

    always_comb begin
        word_next = in_word;
        if (in_word.op == OP_MUL) begin
            word_next.hi = {1'b0, add_sum[DATA_W:1]};
            word_next.lo = {add_sum[0], in_word.lo[DATA_W-1:1]};
        end else begin
            word_next.lo = {in_word.lo[DATA_W-2:0], ~sub_diff[DATA_W+1]};
            word_next.hi = sub_diff[DATA_W+1] ? sh_hi : sub_diff[DATA_W:0];
        end
    end

    assign in_ready  = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_word  = word_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_ready) begin
            valid_reg <= in_valid;
        end
        if (in_ready && in_valid) begin
            word_reg <= word_next;
        end
    end

endmodule

[sv/ckalu_back.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ckalu_back
// Sign fixup, multiply overflow check, result select and output register.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module ckalu_back
    import ckalu_pkg::*;
(
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     in_valid,
    output logic                     in_ready,
    input  word_t                    in_word,
    output logic                     m_valid,
    input  logic                     m_ready,
    output logic signed [DATA_W-1:0] m_value,
    output logic                     m_range_error
);

    logic              valid_reg;
    logic [DATA_W-1:0] value_reg;
    logic              err_reg;
    logic [DATA_W-1:0] value_next;
    logic              err_next;
    logic [DATA_W-1:0] lim;
    logic [DATA_W-1:0] prod_lo;
    logic [DATA_W-1:0] rem;
    logic              neg_q;

    assign neg_q   = in_word.neg_a ^ in_word.neg_b;
    assign lim     = neg_q ? MIN_INT : MAX_INT;
    assign prod_lo = in_word.lo;
    assign rem     = in_word.hi[DATA_W-1:0];

    always_comb begin
        err_next   = in_word.err;
        value_next = in_word.res;
        case (in_word.op)
            OP_MUL: begin
                err_next   = (|in_word.hi) || (prod_lo > lim);
                value_next = neg_q ? (~prod_lo + 1'b1) : prod_lo;
            end
            OP_DIV: begin
                value_next = neg_q ? (~prod_lo + 1'b1) : prod_lo;
            end
            OP_MOD: begin
                value_next = in_word.neg_a ? (~rem + 1'b1) : rem;
            end
            default: begin
                value_next = in_word.res;
            end
        endcase
        if (err_next) begin
            value_next = '0;
        end
    end

    assign in_ready      = !valid_reg || m_ready;
    assign m_valid       = valid_reg;
    assign m_value       = value_reg;
    assign m_range_error = err_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_ready) begin
            valid_reg <= in_valid;
        end
        if (in_ready && in_valid) begin
            value_reg <= value_next;
            err_reg   <= err_next;
        end
    end

    `CKALU_ASSERT(a_err_zero, aclk, aresetn, (m_valid && m_range_error) |-> (m_value == '0),
                  "error word carries nonzero value")
    `CKALU_ASSERT_ALWAYS(a_reset_empty, aclk, !aresetn |=> !m_valid,
                         "output valid after reset")
    `CKALU_ASSERT(a_hold, aclk, aresetn,
                  (m_valid && !m_ready) |=> (m_valid && $stable(m_value) && $stable(m_range_error)),
                  "stalled word changed")

endmodule

[sim/tb_checked_int64_alu_unit.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_checked_int64_alu_unit
// Streams opcode/operand words through the checked 64-bit ALU with random
// gaps on both sides and compares each result word with a local prediction.
// ----------------------------------------------------------------------------
module tb_checked_int64_alu_unit;
    import ckalu_pkg::*;

    localparam int WATCHDOG_LIMIT = 20000;

    typedef struct {
        logic [2:0]  op;
        logic [63:0] a;
        logic [63:0] b;
    } alu_req_t;

    typedef struct {
        logic [63:0] value;
        logic        err;
    } alu_res_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    logic [2:0]  s_req_type = '0;
    logic signed [63:0] s_operand_a = '0;
    logic signed [63:0] s_operand_b = '0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic signed [63:0] m_value;
    logic        m_range_error;

    alu_req_t pending_reqs[$];
    alu_res_t expected_results[$];
    int  send_gap = 0;
    int  recv_gap = 0;
    int  idle_cycles = 0;
    bit  failed = 1'b0;

    checked_int64_alu_unit dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_req_type(s_req_type),
        .s_operand_a(s_operand_a), .s_operand_b(s_operand_b),
        .m_valid(m_valid), .m_ready(m_ready),
        .m_value(m_value), .m_range_error(m_range_error)
    );

    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    function automatic alu_res_t compute_alu(alu_req_t r);
        alu_res_t o;
        logic signed [63:0] sa;
        logic signed [63:0] sb;
        logic signed [127:0] prod;
        sa = r.a;
        sb = r.b;
        o.value = '0;
        o.err = 1'b0;
        case (r.op)
            OP_ADD: begin
                o.value = r.a + r.b;
                o.err = (r.a[63] == r.b[63]) && (o.value[63] != r.a[63]);
            end
            OP_SUB: begin
                o.value = r.a - r.b;
                o.err = (r.a[63] != r.b[63]) && (o.value[63] != r.a[63]);
            end
            OP_MUL: begin
                prod = 128'(sa) * 128'(sb);
                o.value = prod[63:0];
                o.err = (prod[127:63] != {65{prod[63]}});
            end
            OP_DIV, OP_MOD: begin
                if (r.b == '0 || (r.a == MIN_INT && r.b == '1))
                    o.err = 1'b1;
                else
                    o.value = (r.op == OP_DIV) ? sa / sb : sa % sb;
            end
            OP_SHL: begin
                if (r.b > 64'd63) o.err = 1'b1;
                else o.value = r.a << r.b[5:0];
            end
            OP_SHR: begin
                if (r.b > 64'd63) o.err = 1'b1;
                else o.value = sa >>> r.b[5:0];
            end
            default: o.err = 1'b1;
        endcase
        if (o.err) o.value = '0;
        return o;
    endfunction

    function automatic logic [63:0] rand_operand();
        logic [63:0] v;
        case ($urandom_range(0, 9))
            0: v = MIN_INT;
            1: v = MAX_INT;
            2: v = '1;
            3: v = 64'(signed'($urandom_range(0, 6)) - 3);
            4: v = {32'($signed($urandom()) >>> 31), $urandom()};
            5: v = 64'(1) << $urandom_range(0, 63);
            default: v = {$urandom(), $urandom()};
        endcase
        return v;
    endfunction

    function automatic int rand_gap();
        int g;
        g = $urandom_range(0, 99);
        if (g < 55) return 0;
        if (g < 90) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    task automatic push_req(logic [2:0] op, logic [63:0] a, logic [63:0] b);
        alu_req_t r;
        r.op = op;
        r.a = a;
        r.b = b;
        pending_reqs.push_back(r);
    endtask

    // driver
    always @(posedge aclk) begin
        alu_req_t r;
        if (aresetn) begin
            if (s_valid && s_ready) begin
                expected_results.push_back(compute_alu(pending_reqs.pop_front()));
                send_gap = rand_gap();
            end
            if (!(s_valid && !s_ready)) begin
                if (send_gap > 0 || pending_reqs.size() == 0) begin
                    if (send_gap > 0) send_gap--;
                    s_valid <= 1'b0;
                end else begin
                    r = pending_reqs[0];
                    s_valid <= 1'b1;
                    s_req_type <= r.op;
                    s_operand_a <= r.a;
                    s_operand_b <= r.b;
                end
            end
        end
    end

    // monitor
    always @(posedge aclk) begin
        alu_res_t e;
        if (aresetn) begin
            if (m_valid && m_ready) begin
                if (expected_results.size() == 0) begin
                    $display("%0t: unexpected word value=%h err=%b", $time, m_value,
                             m_range_error);
                    failed = 1'b1;
                end else begin
                    e = expected_results.pop_front();
                    if (m_value !== e.value) begin
                        $display("%0t: value mismatch expected %h actual %h", $time,
                                 e.value, m_value);
                        failed = 1'b1;
                    end
                    if (m_range_error !== e.err) begin
                        $display("%0t: range_error mismatch expected %b actual %b", $time,
                                 e.err, m_range_error);
                        failed = 1'b1;
                    end
                end
            end
            if (recv_gap > 0) begin
                recv_gap--;
                m_ready <= 1'b0;
            end else begin
                m_ready <= 1'b1;
                recv_gap = rand_gap();
            end
            if ((s_valid && s_ready) || (m_valid && m_ready)) idle_cycles = 0;
            else idle_cycles++;
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("status: fail");
                $finish;
            end
        end
    end

    initial begin
        int n;
        push_req(OP_ADD, MAX_INT, 64'd1);
        push_req(OP_ADD, MIN_INT, '1);
        push_req(OP_ADD, 64'd5, '1);
        push_req(OP_SUB, MIN_INT, 64'd1);
        push_req(OP_SUB, 64'd0, MIN_INT);
        push_req(OP_SUB, '1, MIN_INT);
        push_req(OP_MUL, MIN_INT, '1);
        push_req(OP_MUL, MIN_INT, 64'd1);
        push_req(OP_MUL, 64'h1_0000_0000, 64'h8000_0000);
        push_req(OP_MUL, 64'hFFFF_FFFF_0000_0000, 64'h8000_0000);
        push_req(OP_DIV, 64'd7, 64'd0);
        push_req(OP_DIV, MIN_INT, '1);
        push_req(OP_DIV, -64'sd7, 64'd2);
        push_req(OP_MOD, -64'sd7, 64'd2);
        push_req(OP_MOD, MIN_INT, '1);
        push_req(OP_MOD, 64'd7, 64'd0);
        push_req(OP_SHL, '1, 64'd63);
        push_req(OP_SHL, 64'd1, 64'd64);
        push_req(OP_SHL, 64'd1, '1);
        push_req(OP_SHR, MIN_INT, 64'd63);
        push_req(OP_SHR, MIN_INT, 64'd0);
        push_req(OP_SHR, MAX_INT, MIN_INT);
        push_req(3'd7, MAX_INT, MAX_INT);
        for (int i = 0; i < 1600; i++) begin
            n = $urandom_range(0, 15);
            push_req(n < 14 ? 3'(n % 7) : 3'd7, rand_operand(),
                     (n % 7 >= 5 && $urandom_range(0, 3) != 0)
                         ? 64'($urandom_range(0, 63)) : rand_operand());
        end
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        wait (pending_reqs.size() == 0 && expected_results.size() == 0);
        repeat (200) @(posedge aclk);
        if (!failed && expected_results.size() == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end
endmodule

[filelist.f]
+incdir+sv
sv/ckalu_pkg.sv
sv/ckalu_front.sv
sv/ckalu_cell.sv
sv/ckalu_back.sv
sv/checked_int64_alu_unit.sv
sim/tb_checked_int64_alu_unit.sv
